// ===== hw/rtl/utf8_to_json_escape_macros.svh =====
// Assertion macros for the escaper. Define NO_ASSERTIONS to drop them.
`ifndef UTF8_TO_JSON_ESCAPE_MACROS_SVH
`define UTF8_TO_JSON_ESCAPE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define UJE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uje: implication violated");
// next-cycle implication
`define UJE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uje: next-cycle implication violated");
`else
`define UJE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define UJE_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/uje_pkg.sv =====
`default_nettype none
package uje_pkg;

  localparam int MAX_RESULTS = 12;
  localparam int HEX_LEN     = 6;   // "\uXXXX"

  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_END  = 1'b1;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef struct packed {
    logic       action;
    logic [7:0] in_byte;
  } uje_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;
  } uje_out_t;

  typedef logic [MAX_RESULTS-1:0][7:0] uje_chars_t;
  typedef logic [HEX_LEN-1:0][7:0]     uje_hex_t;

  typedef struct packed {
    uje_chars_t chars;
    logic [3:0] cnt;
  } uje_esc_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    if (d < 4'd10) begin
      return 8'h30 + {4'b0, d};
    end else begin
      return 8'h57 + {4'b0, d};  // lowercase a..f
    end
  endfunction

  function automatic uje_hex_t hex_escape(input logic [15:0] v);
    uje_hex_t h;
    h[0] = CH_BSL;
    h[1] = CH_U;
    h[2] = hex_digit(v[15:12]);
    h[3] = hex_digit(v[11:8]);
    h[4] = hex_digit(v[7:4]);
    h[5] = hex_digit(v[3:0]);
    return h;
  endfunction

  // Escape one code point; chars[0] goes out first.
  function automatic uje_esc_t escape_code(input logic [20:0] c);
    uje_esc_t   r;
    logic [20:0] v;
    logic [15:0] hi;
    logic [15:0] lo;
    r.chars = '0;
    r.cnt   = '0;
    v  = c - 21'h10000;
    hi = 16'hD800 | {5'b0, v[20:10]};
    lo = 16'hDC00 | {6'b0, v[9:0]};
    if (c <= 21'h7F) begin
      if (c[7:0] == CH_LF) begin
        r.chars[0] = CH_BSL;
        r.chars[1] = CH_R;
        r.chars[2] = CH_BSL;
        r.chars[3] = CH_N;
        r.cnt      = 4'd4;
      end else if (c[7:0] == CH_QUOTE || c[7:0] == CH_BSL) begin
        r.chars[0] = CH_BSL;
        r.chars[1] = c[7:0];
        r.cnt      = 4'd2;
      end else if (c < 21'h20) begin
        r.chars[HEX_LEN-1:0] = hex_escape(c[15:0]);
        r.cnt                = 4'(HEX_LEN);
      end else begin
        r.chars[0] = c[7:0];
        r.cnt      = 4'd1;
      end
    end else if (c > 21'hFFFF) begin
      r.chars[HEX_LEN-1:0]         = hex_escape(hi);
      r.chars[2*HEX_LEN-1:HEX_LEN] = hex_escape(lo);
      r.cnt                        = 4'(2*HEX_LEN);
    end else begin
      r.chars[HEX_LEN-1:0] = hex_escape(c[15:0]);
      r.cnt                = 4'(HEX_LEN);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/utf8_to_json_escape.sv =====
// UTF-8 to JSON string escaper. Raw bytes enter on the text channel, escaped ASCII
// characters leave on the esc channel, one character per beat, with last set on the
// final character of each input item; an end-of-string item flushes any held marker
// bytes and gives one terminator beat (kind end, or kind error if a sequence was left
// open). Each item is latched, decoded and escaped in a single pass into a 12-entry
// character buffer, which drains one beat per cycle while esc_stall is low. An item
// yields n results (0 to 12): plain ASCII runs at one byte per cycle when the esc side
// does not stall, a \uXXXX escape gives 6 results and a surrogate pair 12. The input
// beat is registered in s1_item, then its results in the character buffer. Bytes that
// produce no result (held markers, non-final continuation bytes) pass at one per cycle
// while no earlier results are still draining.
`default_nettype none
`include "utf8_to_json_escape_macros.svh"
module utf8_to_json_escape (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            text_valid,
  output logic                 text_stall,
  input  wire uje_pkg::uje_in_t text,
  output logic                 esc_valid,
  input  wire logic            esc_stall,
  output uje_pkg::uje_out_t    esc
);

  // input stage
  logic             s1_valid;
  uje_pkg::uje_in_t s1_item;

  // decoder state
  logic [20:0] code_acc, code_acc_next;
  logic [1:0]  cont_left, cont_left_next;
  logic [1:0]  mark_cnt, mark_cnt_next;
  logic [1:0]  mark_first, mark_first_next;

  // result buffer
  logic                res_valid;
  uje_pkg::uje_chars_t res_chars;
  logic [3:0]          res_cnt;
  logic [3:0]          res_idx;
  logic [1:0]          res_kind;

  logic res_last, res_take, s1_go;

  // single-pass decode
  logic        pre;
  logic        tail_code;
  logic        tail_single;
  logic [1:0]  single_kind;
  logic [20:0] tail_c;
  logic [20:0] acc_shift;
  logic [1:0]  cont_dec;
  logic [7:0]  b;
  uje_pkg::uje_esc_t   esc_code;
  uje_pkg::uje_chars_t tail_chars;
  logic [3:0]          tail_cnt;
  uje_pkg::uje_chars_t chars_next;
  logic [4:0]          cnt_sum;
  logic [3:0]          cnt_next;
  logic [1:0]          kind_next;

  assign res_last   = res_idx == (res_cnt - 4'd1);
  assign res_take   = res_valid && !esc_stall;
  assign s1_go      = s1_valid && (!res_valid || (res_take && res_last));
  assign text_stall = s1_valid && !s1_go;

  assign esc_valid    = res_valid;
  assign esc.out_byte = res_chars[res_idx];
  assign esc.kind     = res_last ? res_kind : uje_pkg::KIND_CHAR;
  assign esc.last     = res_last;

  assign b         = s1_item.in_byte;
  assign acc_shift = {code_acc[14:0], 6'b0} | {15'b0, b[5:0]};
  assign cont_dec  = cont_left - 2'd1;

  always_comb begin
    code_acc_next   = code_acc;
    cont_left_next  = cont_left;
    mark_cnt_next   = mark_cnt;
    mark_first_next = mark_first;
    pre             = 1'b0;
    tail_code       = 1'b0;
    tail_single     = 1'b0;
    single_kind     = uje_pkg::KIND_ERR;
    tail_c          = '0;

    if (s1_item.action == uje_pkg::ACT_END) begin
      pre         = (mark_cnt == 2'd1) || (mark_cnt == 2'd2);
      tail_single = 1'b1;
      // a held 0xFF becomes a lead that leaves three continuations open
      single_kind = (cont_left != 2'd0 || mark_cnt == 2'd2) ? uje_pkg::KIND_ERR
                                                             : uje_pkg::KIND_END;
      code_acc_next   = '0;
      cont_left_next  = '0;
      mark_cnt_next   = '0;
      mark_first_next = '0;
    end else if (cont_left != 2'd0) begin
      if (b == 8'h00) begin
        tail_single    = 1'b1;
        code_acc_next  = '0;
        cont_left_next = '0;
      end else begin
        cont_left_next = cont_dec;
        if (cont_dec == 2'd0) begin
          tail_code     = 1'b1;
          tail_c        = acc_shift;
          code_acc_next = '0;
        end else begin
          code_acc_next = acc_shift;
        end
      end
    end else if (mark_cnt == 2'd2) begin
      if (b == 8'hFE) begin
        mark_cnt_next   = '0;
        mark_first_next = '0;
      end else begin
        pre             = 1'b1;
        mark_cnt_next   = '0;
        mark_first_next = '0;
        if (b == 8'h00) begin
          tail_single    = 1'b1;
          code_acc_next  = '0;
          cont_left_next = '0;
        end else begin
          code_acc_next  = {12'b0, 3'b111, b[5:0]};
          cont_left_next = 2'd2;
        end
      end
    end else if (mark_cnt == 2'd1 && b == 8'hFF) begin
      mark_cnt_next = 2'd2;
    end else begin
      // lead byte, after flushing a single held marker if there is one
      if (mark_cnt == 2'd1) begin
        pre             = 1'b1;
        mark_first_next = '0;
      end
      mark_cnt_next = '0;
      if (b == 8'h02 || b == 8'h03) begin
        mark_cnt_next   = 2'd1;
        mark_first_next = b[1:0];
      end else if (!b[7]) begin
        tail_code = 1'b1;
        tail_c    = {13'b0, b};
      end else if (!b[5]) begin
        code_acc_next  = {16'b0, b[4:0]};
        cont_left_next = 2'd1;
      end else if (!b[4]) begin
        code_acc_next  = {17'b0, b[3:0]};
        cont_left_next = 2'd2;
      end else begin
        code_acc_next  = {18'b0, b[2:0]};
        cont_left_next = 2'd3;
      end
    end
  end

  always_comb begin
    esc_code = uje_pkg::escape_code(tail_c);
    if (tail_code) begin
      tail_chars = esc_code.chars;
      tail_cnt   = esc_code.cnt;
    end else begin
      tail_chars = '0;
      tail_cnt   = tail_single ? 4'd1 : 4'd0;
    end
    kind_next = tail_single ? single_kind : uje_pkg::KIND_CHAR;
    if (pre) begin
      chars_next = '0;
      chars_next[uje_pkg::HEX_LEN-1:0] = uje_pkg::hex_escape({14'b0, mark_first});
      chars_next[uje_pkg::MAX_RESULTS-1:uje_pkg::HEX_LEN] =
        tail_chars[uje_pkg::MAX_RESULTS-uje_pkg::HEX_LEN-1:0];
      cnt_sum = 5'(uje_pkg::HEX_LEN) + {1'b0, tail_cnt};
    end else begin
      chars_next = tail_chars;
      cnt_sum    = {1'b0, tail_cnt};
    end
    cnt_next = (cnt_sum > 5'(uje_pkg::MAX_RESULTS)) ? 4'(uje_pkg::MAX_RESULTS)
                                                    : cnt_sum[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      res_valid  <= 1'b0;
      res_idx    <= '0;
      code_acc   <= '0;
      cont_left  <= '0;
      mark_cnt   <= '0;
      mark_first <= '0;
    end else begin
      if (text_valid && !text_stall) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        code_acc   <= code_acc_next;
        cont_left  <= cont_left_next;
        mark_cnt   <= mark_cnt_next;
        mark_first <= mark_first_next;
        res_valid  <= cnt_next != 4'd0;
        res_idx    <= '0;
      end else if (res_take) begin
        if (res_last) begin
          res_valid <= 1'b0;
        end else begin
          res_idx <= res_idx + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && !text_stall) begin
      s1_item <= text;
    end
    if (s1_go) begin
      res_chars <= chars_next;
      res_cnt   <= cnt_next;
      res_kind  <= kind_next;
    end
  end

  `UJE_ASSERT_IMP(a_idx_in_range, clk, rst, res_valid, res_cnt != 4'd0 && res_idx < res_cnt)
  `UJE_ASSERT_IMP(a_cont_no_marker, clk, rst, cont_left != 2'd0, mark_cnt == 2'd0)
  `UJE_ASSERT_NXT(a_drain_empty, clk, rst, res_take && res_last && !s1_go, !esc_valid)

endmodule
`default_nettype wire

// ===== dv/tb_utf8_to_json_escape.sv =====
`timescale 1ns / 100ps

module tb_utf8_to_json_escape;
  import uje_pkg::*;

  localparam int N_ITEMS     = 450;
  localparam int CALM_FROM   = 420;     // no idling on either side past this item
  localparam int DRAIN_AT    = 250;
  localparam int HOLD_AT     = 120;     // accepted beats before the long receiver hold
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;
  localparam int LIMIT       = 600000;

  localparam logic [7:0] MARK_STX = 8'h02;
  localparam logic [7:0] MARK_ETX = 8'h03;
  localparam logic [7:0] MARK_B1  = 8'hFF;
  localparam logic [7:0] MARK_B2  = 8'hFE;

  typedef struct packed {
    uje_in_t beat;
    logic    drain;   // wait for every pending char before sending this beat
    logic    calm;
  } stim_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      text_valid = 1'b0;
  logic      text_stall;
  uje_in_t   text = '0;
  logic      esc_valid;
  logic      esc_stall = 1'b0;
  uje_out_t  esc;

  stim_t     stim_q[$];
  uje_out_t  expected_q[$];
  uje_out_t  step_res[$];

  // escaper state as predicted
  logic [20:0] cp_acc  = '0;
  logic [1:0]  cp_left = '0;
  logic [1:0]  mk_cnt  = '0;
  logic [1:0]  mk_lo   = '0;

  int  err_cnt = 0;
  int  beats_in = 0;
  int  cycles = 0;
  bit  drain_req = 1'b0;

  int  tx_gap, tx_rate, tx_mode_cnt;
  bit  tx_drain, calm;
  int  rx_left, rx_hold_left, rx_rate, rx_mode_cnt;
  bit  rx_hold_done;

  utf8_to_json_escape dut (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text       (text),
    .esc_valid  (esc_valid),
    .esc_stall  (esc_stall),
    .esc        (esc)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------- prediction ----------------

  function automatic void emit(logic [7:0] ch, logic [1:0] k);
    uje_out_t r;
    if (step_res.size() < MAX_RESULTS) begin
      r.out_byte = ch;
      r.kind     = k;
      r.last     = 1'b0;
      step_res.push_back(r);
    end
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'b0, n};
    return 8'h61 + {4'b0, n} - 8'd10;
  endfunction

  function automatic void emit_uhex(logic [15:0] v);
    emit(CH_BSL, KIND_CHAR);
    emit(CH_U, KIND_CHAR);
    for (int s = 3; s >= 0; s--) emit(hex_char(v[s*4 +: 4]), KIND_CHAR);
  endfunction

  function automatic void emit_code(logic [20:0] c);
    logic [20:0] v;
    v = c - 21'h10000;
    if (c <= 21'h7F) begin
      if (c[7:0] == CH_LF) begin
        emit(CH_BSL, KIND_CHAR);
        emit(CH_R, KIND_CHAR);
        emit(CH_BSL, KIND_CHAR);
        emit(CH_N, KIND_CHAR);
      end else if (c[7:0] == CH_QUOTE || c[7:0] == CH_BSL) begin
        emit(CH_BSL, KIND_CHAR);
        emit(c[7:0], KIND_CHAR);
      end else if (c < 21'h20) begin
        emit_uhex(c[15:0]);
      end else begin
        emit(c[7:0], KIND_CHAR);
      end
    end else if (c > 21'hFFFF) begin
      emit_uhex(16'hD800 | {5'b0, v[20:10]});
      emit_uhex(16'hDC00 | {6'b0, v[9:0]});
    end else begin
      emit_uhex(c[15:0]);
    end
  endfunction

  function automatic void decode_lead(logic [7:0] b);
    if (mk_cnt == 2'd0 && (b == MARK_STX || b == MARK_ETX)) begin
      mk_cnt = 2'd1;
      mk_lo  = b[1:0];
    end else begin
      mk_cnt = 2'd0;
      if (!b[7]) begin
        emit_code({13'b0, b});
      end else if (!b[5]) begin
        cp_acc  = {16'b0, b[4:0]};
        cp_left = 2'd1;
      end else if (!b[4]) begin
        cp_acc  = {17'b0, b[3:0]};
        cp_left = 2'd2;
      end else begin
        cp_acc  = {18'b0, b[2:0]};
        cp_left = 2'd3;
      end
    end
  endfunction

  function automatic void decode_cont(logic [7:0] b);
    if (b == 8'h00) begin
      emit(8'h00, KIND_ERR);
      cp_acc  = '0;
      cp_left = '0;
    end else begin
      cp_acc  = {cp_acc[14:0], b[5:0]};
      cp_left = cp_left - 2'd1;
      if (cp_left == 2'd0) begin
        emit_code(cp_acc);
        cp_acc = '0;
      end
    end
  endfunction

  // held marker goes out as \u0002 / \u0003; a held 0xFF then acts as a lead
  function automatic void flush_marker();
    logic [1:0] held;
    held   = mk_cnt;
    mk_cnt = 2'd0;
    emit_code({19'b0, mk_lo});
    mk_lo  = 2'd0;
    if (held == 2'd2) decode_lead(MARK_B1);
  endfunction

  function automatic void escape_beat(uje_in_t t);
    uje_out_t r;
    step_res.delete();
    if (t.action == ACT_END) begin
      if (mk_cnt == 2'd1 || mk_cnt == 2'd2) flush_marker();
      emit(8'h00, (cp_left != 2'd0) ? KIND_ERR : KIND_END);
      cp_acc  = '0;
      cp_left = '0;
      mk_cnt  = '0;
      mk_lo   = '0;
    end else if (cp_left != 2'd0) begin
      decode_cont(t.in_byte);
    end else if (mk_cnt == 2'd1) begin
      if (t.in_byte == MARK_B1) begin
        mk_cnt = 2'd2;
      end else begin
        flush_marker();
        decode_lead(t.in_byte);
      end
    end else if (mk_cnt == 2'd2) begin
      if (t.in_byte == MARK_B2) begin
        mk_cnt = 2'd0;
        mk_lo  = 2'd0;
      end else begin
        flush_marker();
        decode_cont(t.in_byte);
      end
    end else begin
      mk_cnt = 2'd0;
      decode_lead(t.in_byte);
    end
    if (step_res.size() != 0) begin
      r = step_res.pop_back();
      r.last = 1'b1;
      step_res.push_back(r);
    end
    foreach (step_res[i]) expected_q.push_back(step_res[i]);
  endfunction

  // ---------------- stimulus ----------------

  function automatic void queue_beat(logic act, logic [7:0] b);
    stim_t s;
    s.beat.action  = act;
    s.beat.in_byte = b;
    s.drain        = drain_req;
    s.calm         = (stim_q.size() >= CALM_FROM);
    drain_req      = 1'b0;
    stim_q.push_back(s);
  endfunction

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  function automatic int pick_rate();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 50;
    endcase
  endfunction

  initial begin : run
    logic [7:0] b;
    int         n_cont;
    bit         drain_placed;

    drain_placed = 1'b0;

    // directed: field extremes and every escape form
    queue_beat(ACT_END, 8'hFF);
    queue_beat(ACT_DATA, 8'h7F);
    queue_beat(ACT_DATA, 8'h1F);
    queue_beat(ACT_DATA, 8'h00);
    queue_beat(ACT_DATA, CH_LF);
    queue_beat(ACT_DATA, CH_QUOTE);
    queue_beat(ACT_DATA, CH_BSL);
    queue_beat(ACT_DATA, 8'hC3);
    queue_beat(ACT_DATA, 8'hA9);
    queue_beat(ACT_DATA, 8'hE2);
    queue_beat(ACT_DATA, 8'h82);
    queue_beat(ACT_DATA, 8'hAC);
    queue_beat(ACT_DATA, 8'hF7);      // largest code: surrogate pair
    queue_beat(ACT_DATA, 8'hBF);
    queue_beat(ACT_DATA, 8'hBF);
    queue_beat(ACT_DATA, 8'hBF);
    queue_beat(ACT_DATA, MARK_STX);   // marker sequence, dropped
    queue_beat(ACT_DATA, MARK_B1);
    queue_beat(ACT_DATA, MARK_B2);
    queue_beat(ACT_DATA, MARK_ETX);   // broken marker
    queue_beat(ACT_DATA, 8'h41);
    queue_beat(ACT_DATA, 8'hC3);      // zero continuation
    queue_beat(ACT_DATA, 8'h00);
    queue_beat(ACT_DATA, MARK_STX);   // held 0xFF becomes a lead, string ends open
    queue_beat(ACT_DATA, MARK_B1);
    queue_beat(ACT_DATA, 8'h80);
    queue_beat(ACT_END, 8'h00);
    queue_beat(ACT_DATA, MARK_ETX);   // end with a marker held
    queue_beat(ACT_END, 8'h5A);

    drain_req = 1'b1;
    while (stim_q.size() < N_ITEMS) begin
      if (!drain_placed && stim_q.size() >= DRAIN_AT) begin
        drain_req    = 1'b1;
        drain_placed = 1'b1;
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: begin
          case ($urandom_range(0, 13))
            0:       b = CH_LF;
            1:       b = CH_QUOTE;
            2:       b = CH_BSL;
            3:       b = 8'h00;
            4:       b = 8'h1F;
            5:       b = 8'h7F;
            6:       b = 8'h20;
            default: b = 8'($urandom_range(0, 127));
          endcase
          queue_beat(ACT_DATA, b);
        end
        6, 7: begin
          queue_beat(ACT_DATA, {3'b110, 5'($urandom)});
          queue_beat(ACT_DATA, cont_byte());
        end
        8, 9: begin
          queue_beat(ACT_DATA, {4'b1110, 4'($urandom)});
          queue_beat(ACT_DATA, cont_byte());
          queue_beat(ACT_DATA, cont_byte());
        end
        10, 18: begin
          // 0xF0..0xFF all take three continuations
          queue_beat(ACT_DATA, {4'b1111, 4'($urandom)});
          for (int i = 0; i < 3; i++) queue_beat(ACT_DATA, cont_byte());
        end
        11: begin
          queue_beat(ACT_DATA, $urandom_range(0, 1) ? MARK_STX : MARK_ETX);
          queue_beat(ACT_DATA, MARK_B1);
          queue_beat(ACT_DATA, MARK_B2);
        end
        12: begin
          queue_beat(ACT_DATA, $urandom_range(0, 1) ? MARK_STX : MARK_ETX);
          if ($urandom_range(0, 1)) queue_beat(ACT_DATA, MARK_B1);
          if ($urandom_range(0, 3) == 0) queue_beat(ACT_END, 8'($urandom));
          else queue_beat(ACT_DATA, 8'($urandom));
        end
        13: begin
          n_cont = $urandom_range(1, 3);
          case (n_cont)
            1:       queue_beat(ACT_DATA, {3'b110, 5'($urandom)});
            2:       queue_beat(ACT_DATA, {4'b1110, 4'($urandom)});
            default: queue_beat(ACT_DATA, {4'b1111, 4'($urandom)});
          endcase
          for (int i = $urandom_range(1, n_cont); i > 1; i--) queue_beat(ACT_DATA, cont_byte());
          queue_beat(ACT_DATA, 8'h00);
        end
        14: begin
          n_cont = $urandom_range(1, 3);
          case (n_cont)
            1:       queue_beat(ACT_DATA, {3'b110, 5'($urandom)});
            2:       queue_beat(ACT_DATA, {4'b1110, 4'($urandom)});
            default: queue_beat(ACT_DATA, {4'b1111, 4'($urandom)});
          endcase
          for (int i = $urandom_range(0, n_cont - 1); i > 0; i--)
            queue_beat(ACT_DATA, cont_byte());
          if ($urandom_range(0, 1)) queue_beat(ACT_END, 8'($urandom));
        end
        15, 19: queue_beat(ACT_END, 8'($urandom));
        default: queue_beat(ACT_DATA, 8'($urandom));
      endcase
    end
    queue_beat(ACT_END, 8'($urandom));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || text_valid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // ---------------- driver ----------------

  always @(posedge clk) begin : driver
    stim_t nxt;
    logic  nv;
    if (rst) begin
      text_valid  <= 1'b0;
      tx_gap      <= 0;
      tx_drain    <= 1'b0;
      tx_rate     <= 0;
      tx_mode_cnt <= 0;
      calm        <= 1'b0;
    end else begin
      if (tx_mode_cnt == 0) begin
        tx_rate     <= pick_rate();
        tx_mode_cnt <= 96;
      end else begin
        tx_mode_cnt <= tx_mode_cnt - 1;
      end
      // a stalled beat stays put
      if (!(text_valid && text_stall)) begin
        nv = 1'b0;
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
        end else if (tx_drain) begin
          if (expected_q.size() == 0) tx_drain <= 1'b0;
        end else if (stim_q.size() != 0) begin
          nxt = stim_q[0];
          if (nxt.drain) begin
            nxt = stim_q.pop_front();
            nxt.drain = 1'b0;
            stim_q.push_front(nxt);
            tx_drain <= 1'b1;
          end else if (!calm && rx_hold_left == 0 && $urandom_range(0, 99) < tx_rate) begin
            tx_gap <= $urandom_range(0, 18);
          end else begin
            nxt = stim_q.pop_front();
            text <= nxt.beat;
            calm <= nxt.calm;
            nv   = 1'b1;
          end
        end
        text_valid <= nv;
      end
    end
  end

  // ---------------- receiver stall ----------------

  always @(posedge clk) begin : receiver
    if (rst) begin
      esc_stall    <= 1'b0;
      rx_left      <= 0;
      rx_hold_left <= 0;
      rx_hold_done <= 1'b0;
      rx_rate      <= 0;
      rx_mode_cnt  <= 0;
    end else begin
      if (rx_mode_cnt == 0) begin
        rx_rate     <= pick_rate();
        rx_mode_cnt <= 128;
      end else begin
        rx_mode_cnt <= rx_mode_cnt - 1;
      end
      if (rx_hold_left != 0) begin
        rx_hold_left <= rx_hold_left - 1;
        esc_stall    <= (rx_hold_left != 1);
      end else if (!rx_hold_done && beats_in >= HOLD_AT) begin
        // long hold so the char buffer fills and text backs up
        rx_hold_done <= 1'b1;
        rx_hold_left <= HOLD_CYCLES;
        esc_stall    <= 1'b1;
      end else if (rx_left != 0) begin
        rx_left   <= rx_left - 1;
        esc_stall <= (rx_left != 1);
      end else if (!calm && $urandom_range(0, 99) < rx_rate) begin
        rx_left   <= $urandom_range(1, 19);
        esc_stall <= 1'b1;
      end else begin
        esc_stall <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin : monitor
    uje_out_t want;
    if (rst) begin
      cp_acc  = '0;
      cp_left = '0;
      mk_cnt  = '0;
      mk_lo   = '0;
    end else begin
      // predict first so a same-edge result always finds its expectation
      if (text_valid && !text_stall) begin
        escape_beat(text);
        beats_in <= beats_in + 1;
      end
      if (esc_valid && !esc_stall) begin
        if (expected_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected beat: expected none, got byte=%h kind=%0d last=%0b",
                   $time, esc.out_byte, esc.kind, esc.last);
        end else begin
          want = expected_q.pop_front();
          if (esc.out_byte !== want.out_byte || esc.kind !== want.kind ||
              esc.last !== want.last) begin
            err_cnt++;
            $display("%0t: expected byte=%h kind=%0d last=%0b, got byte=%h kind=%0d last=%0b",
                     $time, want.out_byte, want.kind, want.last,
                     esc.out_byte, esc.kind, esc.last);
          end
        end
      end
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/uje_pkg.sv
hw/rtl/utf8_to_json_escape.sv
dv/tb_utf8_to_json_escape.sv
